### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the stable priority queue
// Result status codes, priority limits and the command/status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_ENQ    = 3'd0,
    ST_DEQ    = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_FULL   = 3'd3,
    ST_BADPRI = 3'd4
  } spq_status_t;

  // operation codes on in_mode
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // highest legal priority value (0 is served first)
  localparam logic [1:0] MAX_LEVEL = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic accept;  // take the new beat, do any work that needs no further state
    logic deq;     // head word is on the RAM read port, pop it
    logic walk;    // one step of the backward insertion walk
    logic ins;     // write the new entry into the slot at the head
  } spq_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic quick;   // accepted beat finishes in the accept cycle
    logic is_deq;  // accepted beat is a dequeue
    logic hit;     // walk: entry read is not behind the new one, insert here
    logic last;    // walk: entry read sits at the head
  } spq_stat_t;

endpackage

### rtl/core/stable_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_core: bounded stable priority queue
// Priority 0 is served first; entries of one level leave in arrival order.
//
//   channel  handshake         payload
//   input    start / busy      in_mode, in_priority_req, in_ticket_id
//   result   out_valid strobe  out_status, out_head_priority,
//                              out_head_ticket, out_occupancy
//
// A beat is taken when start is high and busy is low; each beat gives one
// result, strobed for one cycle. Rejected beats, dequeue from empty and
// enqueue into an empty queue finish without leaving idle; a dequeue
// passes through a pop state. An enqueue walks back from the tail one
// entry a cycle through the store RAM port, shifting at most QUEUE_DEPTH - 1 entries.
// Synchronous reset empties the queue; the store itself is not cleared.
// The result side cannot stall; a new beat may be taken in the strobe cycle.
// ----------------------------------------------------------------------------
module stable_priority_queue_core import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [1:0]  in_priority_req,
  input  logic [31:0] in_ticket_id,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [1:0]  out_head_priority,
  output logic [31:0] out_head_ticket,
  output logic [4:0]  out_occupancy
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  // sequencer
  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath
  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_mode),
    .in_priority_req   (in_priority_req),
    .in_ticket_id      (in_ticket_id),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_head_priority (out_head_priority),
    .out_head_ticket   (out_head_ticket),
    .out_occupancy     (out_occupancy)
  );

`ifndef SYNTHESIS
  // an accepted beat either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted beat neither finished nor held busy");

  // leaving a multi-cycle operation always delivers its result
  a_finish_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("operation ended without a result strobe");

  // head fields are zero unless an entry was dequeued
  a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_DEQ)) |->
      ((out_head_ticket == 32'd0) && (out_head_priority == 2'd0)))
    else $error("head fields set on a non-dequeue result");

  // the dispatcher issues one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("overlapping datapath commands");
`endif

endmodule

### rtl/core/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl: operation sequencer
// Accepts a beat, then steps the datapath through a dequeue or an insertion
// walk and returns to idle.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_WALK = 4'b0100,
    S_INS  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = start;
        if (start && !stat.quick) begin
          state_nxt = stat.is_deq ? S_DEQ : S_WALK;
        end
      end
      S_DEQ: begin
        cmd.deq   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.hit) begin
          state_nxt = S_IDLE;
        end else if (stat.last) begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/core/spq_dp.sv
// ----------------------------------------------------------------------------
// spq_dp: queue datapath
// Circular entry store with head pointer and count, walk pointers for
// sorted insertion from the tail, and the result registers.
// ----------------------------------------------------------------------------
module spq_dp import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  spq_cmd_t    cmd,
  output spq_stat_t   stat,
  input  logic        in_mode,
  input  logic [1:0]  in_priority_req,
  input  logic [31:0] in_ticket_id,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [1:0]  out_head_priority,
  output logic [31:0] out_head_ticket,
  output logic [4:0]  out_occupancy
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = ID_WIDTH + 2;

  // pointer helpers, modulo QUEUE_DEPTH
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [1:0]          pri_r, pri_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;

  logic                out_valid_r, out_valid_nxt;
  spq_status_t         status_r, status_nxt;
  logic [1:0]          opri_r, opri_nxt;
  logic [31:0]         oid_r, oid_nxt;
  logic [4:0]          occ_r, occ_nxt;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [EW-1:0]       wdata;
  logic [EW-1:0]       rdata;
  logic [1:0]          rd_pri;
  logic [ID_WIDTH-1:0] rd_id;

  logic [ID_WIDTH+31:0] in_id_ext;
  logic [ID_WIDTH-1:0]  in_id;
  logic [ID_WIDTH+31:0] rd_id_ext;
  logic [CW+4:0]        occ_ext;
  logic [AW:0]          tail_sum;
  logic [AW-1:0]        wr_init;
  logic                 bad_pri;

  assign in_id_ext = {{ID_WIDTH{1'b0}}, in_ticket_id};
  assign in_id     = in_id_ext[ID_WIDTH-1:0];
  assign rd_pri    = rdata[EW-1:ID_WIDTH];
  assign rd_id     = rdata[ID_WIDTH-1:0];
  assign rd_id_ext = {32'b0, rd_id};
  assign occ_ext   = {5'b0, count_nxt};
  assign bad_pri   = (in_priority_req > MAX_LEVEL);

  // first free slot behind the tail: head + count, wrapped once
  always_comb begin
    tail_sum = {1'b0, head_r} + (AW + 1)'(count_r);
    if (tail_sum >= (AW + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (AW + 1)'(QUEUE_DEPTH);
    end
    wr_init = tail_sum[AW-1:0];
  end

  // status to the controller
  always_comb begin
    stat.is_deq = (in_mode == MODE_DEQ);
    if (in_mode == MODE_DEQ) begin
      stat.quick = (count_r == '0);
    end else begin
      stat.quick = bad_pri || (count_r == CW'(QUEUE_DEPTH)) || (count_r == '0);
    end
    stat.hit  = (rd_pri <= pri_r);
    stat.last = (rd_ptr_r == head_r);
  end

  // datapath next state
  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    pri_nxt       = pri_r;
    id_nxt        = id_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    opri_nxt      = 2'b0;
    oid_nxt       = 32'b0;
    we            = 1'b0;
    waddr         = wr_ptr_r;
    wdata         = {pri_r, id_r};

    if (cmd.accept) begin
      pri_nxt = in_priority_req;
      id_nxt  = in_id;
      if (in_mode == MODE_DEQ) begin
        if (count_r == '0) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_EMPTY;
        end else begin
          rd_ptr_nxt = head_r;
          count_nxt  = count_r - 1'b1;
        end
      end else if (bad_pri) begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_BADPRI;
      end else if (count_r == CW'(QUEUE_DEPTH)) begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_FULL;
      end else if (count_r == '0) begin
        // empty store: the new entry becomes the head
        we            = 1'b1;
        waddr         = head_r;
        wdata         = {in_priority_req, in_id};
        count_nxt     = CW'(1);
        out_valid_nxt = 1'b1;
        status_nxt    = ST_ENQ;
      end else begin
        // start the walk at the tail entry
        count_nxt  = count_r + 1'b1;
        wr_ptr_nxt = wr_init;
        rd_ptr_nxt = ptr_dec(wr_init);
      end
    end

    // pop the head word
    if (cmd.deq) begin
      head_nxt      = ptr_inc(head_r);
      out_valid_nxt = 1'b1;
      status_nxt    = ST_DEQ;
      opri_nxt      = rd_pri;
      oid_nxt       = rd_id_ext[31:0];
    end

    // walk step: shift the entry back one slot or drop the new one in
    if (cmd.walk) begin
      we = 1'b1;
      if (stat.hit) begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_ENQ;
      end else begin
        wdata      = rdata;
        wr_ptr_nxt = rd_ptr_r;
        if (!stat.last) begin
          rd_ptr_nxt = ptr_dec(rd_ptr_r);
        end
      end
    end

    // new entry lands at the head slot
    if (cmd.ins) begin
      we            = 1'b1;
      out_valid_nxt = 1'b1;
      status_nxt    = ST_ENQ;
    end

    occ_nxt = occ_ext[4:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    wr_ptr_r <= wr_ptr_nxt;
    pri_r    <= pri_nxt;
    id_r     <= id_nxt;
    if (out_valid_nxt) begin
      status_r <= status_nxt;
      opri_r   <= opri_nxt;
      oid_r    <= oid_nxt;
      occ_r    <= occ_nxt;
    end
  end

  // entry store
  spq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_ptr_nxt),
    .rdata (rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_head_priority = opri_r;
  assign out_head_ticket   = oid_r;
  assign out_occupancy     = occ_r;

endmodule

### dv/stable_priority_queue_core_tb.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_core_tb: self-checking bench for the priority queue
// Drives enqueue/dequeue beats over the start/busy channel. A scoreboard
// keeps its own sorted copy of the queue, predicts each result and checks
// every strobed result field by field. Stimulus is a directed opener
// (empty, full, bad priority, FIFO order within a level) and then random
// bursts that lean to filling, to draining or to neither.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stable_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int QDEPTH     = 16;
  localparam int IDW        = 32;
  localparam int RAND_BEATS = 1350;
  localparam int IDLE_LIMIT = 500;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the queue plus the results still owed
  // --------------------------------------------------------------------------
  class spq_scoreboard;
    localparam int DEPTH = QDEPTH;

    typedef struct {
      logic [2:0]  status;
      logic [1:0]  head_pri;
      logic [31:0] head_ticket;
      logic [4:0]  occupancy;
    } spq_result_t;

    logic [1:0]  held_pri [DEPTH];
    logic [31:0] held_id  [DEPTH];
    int unsigned held_count;
    spq_result_t owed_results [$];
    int unsigned fails;

    function new();
      held_count = 0;
      fails      = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    function int unsigned held();
      return held_count;
    endfunction

    task report(string msg);
      if (fails < 50) $display("MISMATCH @%0t: %s", $time, msg);
      fails++;
    endtask

    // accepted input beat: update the mirror, queue the expected result
    function void note_beat(logic mode, logic [1:0] pri, logic [31:0] id);
      spq_result_t r;
      int unsigned pos;
      r.status      = ST_ENQ;
      r.head_pri    = '0;
      r.head_ticket = '0;
      if (mode == MODE_DEQ) begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status      = ST_DEQ;
          r.head_pri    = held_pri[0];
          r.head_ticket = held_id[0];
          for (int k = 1; k < held_count; k++) begin
            held_pri[k-1] = held_pri[k];
            held_id[k-1]  = held_id[k];
          end
          held_count--;
        end
      end else if (pri > MAX_LEVEL) begin
        r.status = ST_BADPRI;
      end else if (held_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // stable insert: behind every entry of lower or equal value
        pos = 0;
        while (pos < held_count && held_pri[pos] <= pri) pos++;
        for (int k = held_count; k > pos; k--) begin
          held_pri[k] = held_pri[k-1];
          held_id[k]  = held_id[k-1];
        end
        held_pri[pos] = pri;
        held_id[pos]  = id;
        held_count++;
      end
      r.occupancy = held_count[4:0];
      owed_results.push_back(r);
    endfunction

    // strobed result: compare with the oldest owed one
    task check_result(logic [2:0] st, logic [1:0] hp, logic [31:0] ht, logic [4:0] occ);
      spq_result_t e;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result, status %0d", st));
        return;
      end
      e = owed_results.pop_front();
      if (st !== e.status)
        report($sformatf("status %0d, want %0d", st, e.status));
      if (hp !== e.head_pri)
        report($sformatf("head_priority %0d, want %0d", hp, e.head_pri));
      if (ht !== e.head_ticket)
        report($sformatf("head_ticket %h, want %h", ht, e.head_ticket));
      if (occ !== e.occupancy)
        report($sformatf("occupancy %0d, want %0d", occ, e.occupancy));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_mode = MODE_ENQ;
  logic [1:0]  in_priority_req = '0;
  logic [31:0] in_ticket_id = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [1:0]  out_head_priority;
  logic [31:0] out_head_ticket;
  logic [4:0]  out_occupancy;

  spq_scoreboard sb = new();
  int unsigned idle_cycles = 0;

  stable_priority_queue_core #(
    .QUEUE_DEPTH(QDEPTH),
    .ID_WIDTH   (IDW)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_priority_req  (in_priority_req),
    .in_ticket_id     (in_ticket_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_head_priority(out_head_priority),
    .out_head_ticket  (out_head_ticket),
    .out_occupancy    (out_occupancy)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: results first, then the beat taken at the same edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic took_beat;
    logic got_result;
    took_beat  = rst_n && start && (busy === 1'b0);
    got_result = rst_n && (out_valid === 1'b1);
    if (got_result)
      sb.check_result(out_status, out_head_priority, out_head_ticket, out_occupancy);
    if (took_beat)
      sb.note_beat(in_mode, in_priority_req, in_ticket_id);
    // watchdog on cycles with no traffic at all
    if (took_beat || got_result) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat or result for %0d cycles", IDLE_LIMIT);
      $display("stable_priority_queue_core_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  // one beat: idle for gap cycles, then hold start until busy is low
  task automatic send_beat(logic mode, logic [1:0] pri, logic [31:0] id, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= mode;
    in_priority_req <= pri;
    in_ticket_id    <= id;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // hold off until every owed result is back, after first letting the
  // monitor book the last beat
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic int pick_gap(bit no_idle);
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          done;
    int          enq_pct;
    int          burst_len;
    bit          no_idle;
    logic        mode;
    logic [1:0]  pri;
    logic [31:0] id;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: dequeue from empty, bad priority on empty
    send_beat(MODE_DEQ, 2'd3, 32'hFFFF_FFFF, 0);
    send_beat(MODE_ENQ, 2'd3, 32'h1234_5678, pick_gap(0));
    // fill to the brim, mixing levels so FIFO order within a level shows
    send_beat(MODE_ENQ, 2'd2, 32'hFFFF_FFFF, pick_gap(0));
    send_beat(MODE_ENQ, 2'd0, 32'h0000_0000, pick_gap(0));
    send_beat(MODE_ENQ, 2'd1, 32'hA5A5_A5A5, pick_gap(0));
    send_beat(MODE_ENQ, 2'd0, 32'h5A5A_5A5A, pick_gap(0));
    send_beat(MODE_ENQ, 2'd2, 32'h0000_0001, 0);
    for (int i = 0; i < QDEPTH - 5; i++)
      send_beat(MODE_ENQ, 2'($urandom_range(0, 2)), $urandom, pick_gap(i < 5));
    // full, and bad priority takes precedence over full
    send_beat(MODE_ENQ, 2'd1, 32'hDEAD_BEEF, pick_gap(0));
    send_beat(MODE_ENQ, 2'd3, 32'hCAFE_F00D, 0);
    // dequeues ignore priority and ticket inputs
    send_beat(MODE_DEQ, 2'd3, 32'hFFFF_FFFF, pick_gap(0));
    send_beat(MODE_DEQ, 2'd0, 32'h0000_0000, 0);
    send_beat(MODE_DEQ, 2'd2, $urandom, pick_gap(0));
    send_beat(MODE_DEQ, 2'd1, $urandom, 0);
    drain();

    // random bursts, each leaning to fill, to drain or to neither
    done = 0;
    while (done < RAND_BEATS) begin
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        default: enq_pct = 15;
      endcase
      burst_len = $urandom_range(20, 60);
      no_idle   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < burst_len; i++) begin
        mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
        pri  = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        if (mode == MODE_DEQ) pri = 2'($urandom);
        id   = $urandom;
        send_beat(mode, pri, id, pick_gap(no_idle));
        done++;
      end
      if ($urandom_range(0, 4) == 0) drain();
    end

    // wind down
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (QDEPTH + 4) @(posedge clk);
    if (sb.pending() != 0) sb.report("results still owed at end of run");

    if (sb.fails == 0) begin
      $display("stable_priority_queue_core_tb OK");
    end else begin
      $display("stable_priority_queue_core_tb NOT OK");
    end
    $finish;
  end

endmodule
